// ----- sv/scpa_pkg.sv -----
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types and constants for the skip/copy patch applier.
// ----------------------------------------------------------------------------
package scpa_pkg;

  // Target address space and field widths.
  localparam int ADDR_BITS = 20;
  localparam int OFS_W     = 20;
  localparam int DATA_W    = 8;
  localparam int LEN_W     = 15;

  // Widths that cover both the address space and the fixed fields.
  localparam int SUM_W   = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;
  localparam int START_W = (ADDR_BITS > OFS_W) ? ADDR_BITS : OFS_W;

  localparam logic [ADDR_BITS-1:0] ADDR_TOP = '1;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [OFS_W-1:0]     ofs_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [LEN_W-1:0]     len_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_COPY = 2'd3
  } phase_t;

  typedef struct packed {
    ofs_t  write_offset;
    data_t write_data;
    logic  patch_end;
    logic  offset_overflow;
  } res_t;

endpackage

// ----- sv/scpa_if.sv -----
// ----------------------------------------------------------------------------
// scpa_in_if / scpa_out_if
// Valid/ready channels for patch bytes and write results.
// ----------------------------------------------------------------------------
interface scpa_in_if;
  logic             valid;
  logic             ready;
  logic [7:0]       patch_byte;
  logic             first_byte;

  modport source (output valid, output patch_byte, output first_byte, input ready);
  modport sink   (input valid, input patch_byte, input first_byte, output ready);
endinterface

interface scpa_out_if;
  logic             valid;
  logic             ready;
  logic [19:0]      write_offset;
  logic [7:0]       write_data;
  logic             patch_end;
  logic             offset_overflow;

  modport source (output valid, output write_offset, output write_data,
                  output patch_end, output offset_overflow, input ready);
  modport sink   (input valid, input write_offset, input write_data,
                  input patch_end, input offset_overflow, output ready);
endinterface

// ----- sv/scpa_parser.sv -----
// ----------------------------------------------------------------------------
// scpa_parser
// Record parser: header assembly, skip/copy offset tracking, overflow flag.
// ----------------------------------------------------------------------------
module scpa_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  scpa_pkg::data_t       patch_byte,
  input  logic                  first_byte,
  input  scpa_pkg::ofs_t        start_offset,
  output logic                  res_valid,
  output scpa_pkg::res_t        res
);
  import scpa_pkg::*;

  typedef struct packed {
    addr_t ofs;
    logic  ovf;
  } adv_t;

  // Saturating advance of the target offset.
  function automatic adv_t advance(input addr_t ofs, input len_t amt);
    logic [SUM_W-1:0] sum;
    adv_t             r;
    sum = SUM_W'(ofs) + SUM_W'(amt);
    if (sum > SUM_W'(ADDR_TOP)) begin
      r.ofs = ADDR_TOP;
      r.ovf = 1'b1;
    end else begin
      r.ofs = sum[ADDR_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic ofs_t to_out(input addr_t a);
    logic [START_W-1:0] w;
    w = START_W'(a);
    return w[OFS_W-1:0];
  endfunction

  phase_t phase_r, phase_nxt;
  data_t  header_high_r, header_high_nxt;
  len_t   copy_remaining_r, copy_remaining_nxt;
  addr_t  target_offset_r, target_offset_nxt;
  logic   overflow_seen_r, overflow_seen_nxt;

  logic [15:0]        header;
  adv_t               skip_adv;
  adv_t               inc_adv;
  logic [START_W-1:0] start_w;

  assign header   = {header_high_r, patch_byte};
  assign skip_adv = advance(target_offset_r, header[LEN_W-1:0]);
  assign inc_adv  = advance(target_offset_r, len_t'(1));
  assign start_w  = START_W'(start_offset);

  // Next state.
  always_comb begin
    phase_nxt          = phase_r;
    header_high_nxt    = header_high_r;
    copy_remaining_nxt = copy_remaining_r;
    target_offset_nxt  = target_offset_r;
    overflow_seen_nxt  = overflow_seen_r;
    if (first_byte) begin
      if (start_w > START_W'(ADDR_TOP)) begin
        target_offset_nxt = ADDR_TOP;
        overflow_seen_nxt = 1'b1;
      end else begin
        target_offset_nxt = start_w[ADDR_BITS-1:0];
      end
      header_high_nxt    = patch_byte;
      copy_remaining_nxt = '0;
      phase_nxt          = PH_LOW;
    end else begin
      unique case (phase_r)
        PH_HIGH: begin
          header_high_nxt = patch_byte;
          phase_nxt       = PH_LOW;
        end
        PH_LOW: begin
          if (header == '0) begin
            phase_nxt = PH_IDLE;
          end else if (!header[15]) begin
            target_offset_nxt = skip_adv.ofs;
            overflow_seen_nxt = overflow_seen_r | skip_adv.ovf;
            phase_nxt         = PH_HIGH;
          end else begin
            copy_remaining_nxt = header[LEN_W-1:0];
            phase_nxt = (header[LEN_W-1:0] == '0) ? PH_HIGH : PH_COPY;
          end
        end
        PH_COPY: begin
          target_offset_nxt  = inc_adv.ofs;
          overflow_seen_nxt  = overflow_seen_r | inc_adv.ovf;
          copy_remaining_nxt = copy_remaining_r - len_t'(1);
          if (copy_remaining_r == len_t'(1)) begin
            phase_nxt = PH_HIGH;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for the current byte.
  always_comb begin
    res_valid           = 1'b0;
    res.write_offset    = to_out(target_offset_r);
    res.write_data      = '0;
    res.patch_end       = 1'b0;
    res.offset_overflow = overflow_seen_nxt;
    if (!first_byte) begin
      unique case (phase_r)
        PH_LOW: begin
          if (header == '0) begin
            res_valid     = 1'b1;
            res.patch_end = 1'b1;
          end
        end
        PH_COPY: begin
          res_valid      = 1'b1;
          res.write_data = patch_byte;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      header_high_r    <= '0;
      copy_remaining_r <= '0;
      target_offset_r  <= '0;
      overflow_seen_r  <= 1'b0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      header_high_r    <= header_high_nxt;
      copy_remaining_r <= copy_remaining_nxt;
      target_offset_r  <= target_offset_nxt;
      overflow_seen_r  <= overflow_seen_nxt;
    end
  end

endmodule

// ----- sv/scpa_out_stage.sv -----
// ----------------------------------------------------------------------------
// scpa_out_stage
// Result register that decouples the parser from the result channel.
// ----------------------------------------------------------------------------
module scpa_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              res_valid,
  input  scpa_pkg::res_t    res,
  output logic              can_load,
  scpa_out_if.source        out_ch
);
  import scpa_pkg::*;

  logic valid_r;
  res_t data_r;

  // The register can take a new request when empty or being drained.
  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && step && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.write_offset    = data_r.write_offset;
  assign out_ch.write_data      = data_r.write_data;
  assign out_ch.patch_end       = data_r.patch_end;
  assign out_ch.offset_overflow = data_r.offset_overflow;

endmodule

// ----- sv/skip_copy_patch_applier.sv -----
// Path: a patch byte passes the input register and then the result register on its
// way to the result channel; a full result register can hold it in between.
// Throughput: one patch byte per cycle; the parser state update is a single
// registered pass, and a full result register stalls input only while the
// result side withholds ready.
// Reset (synchronous, rst_n low): parser idle awaiting a first byte, offset,
// overflow flag and start offset cleared, no request pending on either side.
// ----------------------------------------------------------------------------
// skip_copy_patch_applier
// Applies a byte-serial skip/copy patch stream and emits target writes.
// ----------------------------------------------------------------------------
module skip_copy_patch_applier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  scpa_pkg::ofs_t     cfg_wdata,
  scpa_in_if.sink            in_ch,
  scpa_out_if.source         out_ch
);
  import scpa_pkg::*;

  ofs_t  start_offset_r;
  logic  s1_valid_r;
  data_t s1_byte_r;
  logic  s1_first_r;

  logic  can_load;
  logic  step;
  logic  res_valid;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= '0;
    end else if (cfg_we) begin
      start_offset_r <= cfg_wdata;
    end
  end

  // Input register: advances whenever the parser can consume its byte.
  assign step        = s1_valid_r && can_load;
  assign in_ch.ready = !s1_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r  <= in_ch.patch_byte;
      s1_first_r <= in_ch.first_byte;
    end
  end

  scpa_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .patch_byte   (s1_byte_r),
    .first_byte   (s1_first_r),
    .start_offset (start_offset_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  scpa_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

endmodule

// ----- bench/skip_copy_patch_applier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skip_copy_patch_applier_checker
// Watches the patch byte, result and start offset ports. It rebuilds the
// parser state from every accepted patch byte, queues the write and end
// results that the byte must cause, and compares each accepted result with
// the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module skip_copy_patch_applier_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  scpa_pkg::ofs_t cfg_wdata,
  scpa_in_if             in_ch,
  scpa_out_if            out_ch,
  output int             fail_count,
  output int             pending_count
);
  import scpa_pkg::*;

  phase_t parse_phase;
  data_t  hdr_high;
  len_t   copy_left;
  addr_t  tgt_ofs;
  logic   ovf_seen;
  ofs_t   start_ofs;
  res_t   expected_writes[$];

  // Moves the target offset forward, pinning it at the top of the address
  // space and raising the sticky flag when it would run past.
  task automatic advance_offset(input len_t amount);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(tgt_ofs) + SUM_W'(amount);
    if (sum > SUM_W'(ADDR_TOP)) begin
      tgt_ofs  = ADDR_TOP;
      ovf_seen = 1'b1;
    end else begin
      tgt_ofs = addr_t'(sum);
    end
  endtask

  task automatic queue_result(input addr_t ofs, input data_t data, input logic is_end);
    res_t r;
    r.write_offset    = ofs_t'(ofs);
    r.write_data      = data;
    r.patch_end       = is_end;
    r.offset_overflow = ovf_seen;
    expected_writes   = {expected_writes, r};
  endtask

  task automatic apply_patch_byte(input data_t pbyte, input logic first);
    logic [15:0] hdr;
    addr_t       wr_ofs;
    if (first) begin
      if (START_W'(start_ofs) > START_W'(ADDR_TOP)) begin
        tgt_ofs  = ADDR_TOP;
        ovf_seen = 1'b1;
      end else begin
        tgt_ofs = addr_t'(start_ofs);
      end
      hdr_high    = pbyte;
      copy_left   = '0;
      parse_phase = PH_LOW;
    end else begin
      case (parse_phase)
        PH_HIGH: begin
          hdr_high    = pbyte;
          parse_phase = PH_LOW;
        end
        PH_LOW: begin
          hdr = {hdr_high, pbyte};
          if (hdr == 16'h0000) begin
            parse_phase = PH_IDLE;
            queue_result(tgt_ofs, '0, 1'b1);
          end else if (!hdr[15]) begin
            advance_offset(hdr[LEN_W-1:0]);
            parse_phase = PH_HIGH;
          end else begin
            copy_left   = hdr[LEN_W-1:0];
            parse_phase = (copy_left == '0) ? PH_HIGH : PH_COPY;
          end
        end
        PH_COPY: begin
          wr_ofs = tgt_ofs;
          advance_offset(len_t'(1));
          copy_left = copy_left - len_t'(1);
          if (copy_left == '0) parse_phase = PH_HIGH;
          queue_result(wr_ofs, pbyte, 1'b0);
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_write(input res_t got);
    res_t want;
    if (expected_writes.size() == 0) begin
      $error("unexpected result: write_offset %h write_data %h patch_end %b overflow %b",
             got.write_offset, got.write_data, got.patch_end, got.offset_overflow);
      fail_count++;
      return;
    end
    want = expected_writes.pop_front();
    if (got.write_offset !== want.write_offset) begin
      $error("write_offset: expected %h, actual %h", want.write_offset, got.write_offset);
      fail_count++;
    end
    if (got.write_data !== want.write_data) begin
      $error("write_data: expected %h, actual %h", want.write_data, got.write_data);
      fail_count++;
    end
    if (got.patch_end !== want.patch_end) begin
      $error("patch_end: expected %b, actual %b", want.patch_end, got.patch_end);
      fail_count++;
    end
    if (got.offset_overflow !== want.offset_overflow) begin
      $error("offset_overflow: expected %b, actual %b",
             want.offset_overflow, got.offset_overflow);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_phase = PH_IDLE;
      hdr_high    = '0;
      copy_left   = '0;
      tgt_ofs     = '0;
      ovf_seen    = 1'b0;
      start_ofs   = '0;
      fail_count  = 0;
      expected_writes.delete();
    end else begin
      // Results leave before the new request is parsed, so a result taken at
      // this edge is never matched against one the current byte causes.
      if (out_ch.valid && out_ch.ready)
        check_write({out_ch.write_offset, out_ch.write_data,
                     out_ch.patch_end, out_ch.offset_overflow});
      if (cfg_we) start_ofs = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        apply_patch_byte(in_ch.patch_byte, in_ch.first_byte);
    end
    pending_count = expected_writes.size();
  end

endmodule

// ----- bench/skip_copy_patch_applier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skip_copy_patch_applier_tb
// Drives patch streams into the applier: a directed opening, then random
// patches of skip and copy records with noise and broken records, over
// several start offsets and idle/stall mixes, one long result hold-off among
// them. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module skip_copy_patch_applier_tb;
  import scpa_pkg::*;

  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam logic [15:0] COPY_FLAG      = 16'h8000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  ofs_t cfg_wdata;

  int   fail_count;
  int   pending_count;
  int   items_sent;
  int   src_idle_pct;
  int   sink_stall_pct;
  logic hold_req;

  scpa_in_if  in_ch();
  scpa_out_if out_ch();

  skip_copy_patch_applier dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  skip_copy_patch_applier_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next request can follow without a gap.
  task automatic send_byte(input data_t pbyte, input logic first, input logic counted);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.patch_byte <= pbyte;
    in_ch.first_byte <= first;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  // A byte may cause no result, so the wait runs on for a drain time after the
  // result queue is empty.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start(input ofs_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_patch();
    int          n_rec;
    int          len;
    logic [15:0] hdr;
    if ($urandom_range(99) < 10) begin
      // Noise: random bytes with the odd restart, in no record shape at all.
      repeat ($urandom_range(1, 6))
        send_byte(data_t'($urandom), logic'($urandom_range(99) < 25), 1'b1);
      return;
    end
    n_rec = $urandom_range(0, 6);
    for (int r = 0; r < n_rec; r++) begin
      if ($urandom_range(99) < 50) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        hdr = COPY_FLAG | 16'(len);
      end else begin
        len = ($urandom_range(99) < 80) ? $urandom_range(1, 255) : $urandom_range(1, 32767);
        hdr = 16'(len);
      end
      send_byte(hdr[15:8], logic'(r == 0), 1'b1);
      send_byte(hdr[7:0], 1'b0, 1'b1);
      if (hdr[15]) begin
        for (int i = 0; i < len; i++) begin
          // Now and then a copy breaks off; a later first byte restarts parsing.
          if ($urandom_range(99) < 2) return;
          send_byte(data_t'($urandom), 1'b0, 1'b1);
        end
      end
    end
    if ($urandom_range(99) < 90) begin
      send_byte(8'h00, logic'(n_rec == 0), 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      repeat ($urandom_range(0, 3)) send_byte(data_t'($urandom), 1'b0, 1'b0);
    end
  endtask

  task automatic run_phase(input int n_items, input ofs_t start, input int src_pct,
                           input int snk_pct);
    int goal;
    wait_idle();
    write_start(start);
    src_idle_pct = src_pct;
    sink_stall_pct <= snk_pct;
    goal = items_sent + n_items;
    while (items_sent < goal) send_patch();
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.patch_byte = '0;
    in_ch.first_byte = 1'b0;
    hold_req         = 1'b0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    items_sent       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, start offset still at its reset value.
    send_byte(8'hFF, 1'b0, 1'b0);   // ignored before any first byte
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b1);   // copy three bytes
    send_byte(8'h03, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);   // empty copy
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b1);   // longest skip
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);   // copy cut short by a restart
    send_byte(8'h05, 1'b0, 1'b1);
    send_byte(8'h11, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);   // restart straight into an end
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h12, 1'b0, 1'b0);   // ignored after the end
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h10, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);

    // Low start offsets keep the sticky overflow clear through these phases.
    src_idle_pct = 0;
    wait_idle();
    write_start(ofs_t'($urandom_range(0, 20'h7FFFF)));
    sink_stall_pct <= 0;
    hold_req       <= 1'b1;
    begin : pressure_phase
      int goal;
      goal = items_sent + 250;
      while (items_sent < goal) send_patch();
    end
    run_phase(200, 20'h00000, 71, 0);
    run_phase(200, ofs_t'($urandom_range(0, 20'h7FFFF)), 0, 71);
    run_phase(200, ofs_t'($urandom_range(0, 20'h7FFFF)), 36, 36);

    // Copy and skip running into the top of the address space.
    wait_idle();
    write_start(20'hFFFFD);
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'h05, 1'b0, 1'b1);
    repeat (5) send_byte(data_t'($urandom), 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h77, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);

    run_phase(200, 20'hFFFFF, 0, 0);
    run_phase(150, 20'hF8000, 36, 36);

    wait_idle();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/scpa_pkg.sv
sv/scpa_if.sv
sv/scpa_parser.sv
sv/scpa_out_stage.sv
sv/skip_copy_patch_applier.sv
bench/skip_copy_patch_applier_checker.sv
bench/skip_copy_patch_applier_tb.sv
